>>> rtl/twcm_pkg.sv
// ----------------------------------------------------------------------------
// twcm_pkg
// Shared types and constants of the textured wall column mapper.
// ----------------------------------------------------------------------------
package twcm_pkg;

    localparam int MAX_TEX_SIZE_DEF = 256;
    localparam int MAX_SCREEN_DEF   = 2048;

    // operand width of the shared signed multiplier
    localparam int MUL_W = 26;

    // divider: (texture height << 16) / line height
    localparam int DIV_N_W = 25;
    localparam int DIV_D_W = 16;

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam logic [1:0] REG_TEX_W = 2'd0;
    localparam logic [1:0] REG_TEX_H = 2'd1;
    localparam logic [1:0] REG_SCR_W = 2'd2;
    localparam logic [1:0] REG_SCR_H = 2'd3;

    localparam logic [8:0]  TEX_W_RST = 9'd64;
    localparam logic [8:0]  TEX_H_RST = 9'd64;
    localparam logic [11:0] SCR_W_RST = 12'd640;
    localparam logic [11:0] SCR_H_RST = 12'd480;

    localparam logic [1:0] FACE_NORTH = 2'd0;
    localparam logic [1:0] FACE_SOUTH = 2'd1;
    localparam logic [1:0] FACE_EAST  = 2'd2;
    localparam logic [1:0] FACE_WEST  = 2'd3;

    typedef struct packed {
        logic [8:0]  texture_width;
        logic [8:0]  texture_height;
        logic [11:0] screen_width;
        logic [11:0] screen_height;
    } cfg_t;

endpackage

>>> rtl/twcm_if.sv
// ----------------------------------------------------------------------------
// twcm_if
// Handshake channels: wall hit items in, pixel items out.
// ----------------------------------------------------------------------------
interface twcm_hit_if;
    logic               valid;
    logic               ready;
    logic               op;
    logic               hit_side;
    logic [23:0]        player_x;
    logic [23:0]        player_y;
    logic signed [20:0] ray_dir_x;
    logic signed [20:0] ray_dir_y;
    logic [23:0]        wall_distance;
    logic [15:0]        line_height;
    logic [10:0]        draw_start;
    logic [10:0]        draw_end;
    logic [10:0]        column;

    modport source (
        output valid, op, hit_side, player_x, player_y, ray_dir_x, ray_dir_y,
               wall_distance, line_height, draw_start, draw_end, column,
        input  ready
    );
    modport sink (
        input  valid, op, hit_side, player_x, player_y, ray_dir_x, ray_dir_y,
               wall_distance, line_height, draw_start, draw_end, column,
        output ready
    );
endinterface

interface twcm_pix_if;
    logic        valid;
    logic        ready;
    logic [1:0]  face;
    logic [15:0] texel_address;
    logic [21:0] frame_address;
    logic        last_row;

    modport source (
        output valid, face, texel_address, frame_address, last_row,
        input  ready
    );
    modport sink (
        input  valid, face, texel_address, frame_address, last_row,
        output ready
    );
endinterface

>>> rtl/twcm_cfg.sv
// ----------------------------------------------------------------------------
// twcm_cfg
// APB register file: texture and screen dimensions.
// ----------------------------------------------------------------------------
module twcm_cfg
    import twcm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t       cfg_reg;
    logic [1:0] idx;
    logic       wr_en;

    assign idx    = paddr[3:2];
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.texture_width  <= TEX_W_RST;
            cfg_reg.texture_height <= TEX_H_RST;
            cfg_reg.screen_width   <= SCR_W_RST;
            cfg_reg.screen_height  <= SCR_H_RST;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_TEX_W: cfg_reg.texture_width  <= pwdata[8:0];
                REG_TEX_H: cfg_reg.texture_height <= pwdata[8:0];
                REG_SCR_W: cfg_reg.screen_width   <= pwdata[11:0];
                REG_SCR_H: cfg_reg.screen_height  <= pwdata[11:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_TEX_W: prdata = DATA_W'(cfg_reg.texture_width);
            REG_TEX_H: prdata = DATA_W'(cfg_reg.texture_height);
            REG_SCR_W: prdata = DATA_W'(cfg_reg.screen_width);
            REG_SCR_H: prdata = DATA_W'(cfg_reg.screen_height);
            default:   prdata = '0;
        endcase
    end

endmodule

>>> rtl/twcm_mul.sv
// ----------------------------------------------------------------------------
// twcm_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module twcm_mul
    import twcm_pkg::*;
(
    input  logic                      clk,
    input  logic signed [MUL_W-1:0]   a,
    input  logic signed [MUL_W-1:0]   b,
    output logic signed [2*MUL_W-1:0] p
);

    logic signed [2*MUL_W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

    assign p = p_reg;

endmodule

>>> rtl/twcm_div.sv
// ----------------------------------------------------------------------------
// twcm_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module twcm_div
    import twcm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [DIV_N_W-1:0] dividend,
    input  logic [DIV_D_W-1:0] divisor,
    output logic               done,
    output logic [DIV_N_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIV_N_W + 1);

    logic               busy_reg;
    logic               done_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [DIV_N_W-1:0] quo_reg;
    logic [DIV_D_W-1:0] rem_reg;
    logic [DIV_D_W-1:0] div_reg;
    logic [DIV_D_W:0]   trial;
    logic [DIV_D_W:0]   diff;
    logic               fits;

    // shift the next dividend bit into the partial remainder
    assign trial = {rem_reg, quo_reg[DIV_N_W-1]};
    assign diff  = trial - {1'b0, div_reg};
    assign fits  = (trial >= {1'b0, div_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIV_N_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIV_N_W-2:0], fits};
            rem_reg <= fits ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> rtl/textured_wall_column_mapper.sv
// ----------------------------------------------------------------------------
// textured_wall_column_mapper
// Raycaster texture column mapping: wall hit in, texel/frame addresses out.
// ----------------------------------------------------------------------------
// An op=0 item sets up one screen column from a wall hit and returns nothing;
// each op=1 item then returns one pixel item (face, texel address, framebuffer
// address, last-row flag) until the column's rows run out, after which op=1
// returns nothing. A setup item keeps the block busy while the 25-step
// shift/subtract divider forms the texture step; a pixel item keeps it
// busy while the single shared multiplier forms the texel and framebuffer
// row products one after the other. A finished pixel item waits in the
// output register, and the next item is accepted meanwhile.
// Registers: texture width at 0x0, texture height at 0x4, screen width at
// 0x8, screen height at 0xC; write them only while the block is idle.
// ----------------------------------------------------------------------------
module textured_wall_column_mapper
    import twcm_pkg::*;
#(
    parameter int MAX_TEX_SIZE = MAX_TEX_SIZE_DEF,
    parameter int MAX_SCREEN   = MAX_SCREEN_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    twcm_hit_if.sink          hit,
    twcm_pix_if.source        pixel,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    localparam int TCOL_W = (MAX_TEX_SIZE > 2) ? $clog2(MAX_TEX_SIZE) : 1;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_HIT  = 4'd1;
    localparam logic [3:0] ST_FRAC = 4'd2;
    localparam logic [3:0] ST_COL  = 4'd3;
    localparam logic [3:0] ST_DIV  = 4'd4;
    localparam logic [3:0] ST_POS  = 4'd5;
    localparam logic [3:0] ST_POSW = 4'd6;
    localparam logic [3:0] ST_TEX  = 4'd7;
    localparam logic [3:0] ST_FRM  = 4'd8;
    localparam logic [3:0] ST_EMIT = 4'd9;

    cfg_t cfg;

    logic [3:0] state_reg, state_next;

    // column state
    logic [10:0]       row_reg;
    logic [10:0]       row_limit_reg;
    logic [31:0]       tex_position_reg;
    logic [DIV_N_W-1:0] tex_step_reg;
    logic [TCOL_W-1:0] tex_column_reg;
    logic [1:0]        face_sel_reg;
    logic [10:0]       screen_column_reg;

    // setup operands
    logic [15:0]        base_reg;
    logic [23:0]        dist_reg;
    logic signed [20:0] dir_reg;
    logic [15:0]        lh_reg;
    logic [15:0]        texel_reg;

    // output register
    logic        out_valid_reg;
    logic [1:0]  out_face_reg;
    logic [15:0] out_texel_reg;
    logic [21:0] out_frame_reg;
    logic        out_last_reg;

    logic [8:0]  tex_w;
    logic [8:0]  tex_h;
    logic        accept;
    logic        out_free;
    logic        emit;
    logic [10:0] ds_masked;
    logic [10:0] de_masked;
    logic        dx_pos;
    logic        dy_pos;
    logic [1:0]  face_new;
    logic [15:0] frac;
    logic [8:0]  col;
    logic [8:0]  tcol_full;
    logic signed [16:0] start_row;
    logic [8:0]  ty;

    logic signed [MUL_W-1:0]   mul_a;
    logic signed [MUL_W-1:0]   mul_b;
    logic signed [2*MUL_W-1:0] mul_p;

    logic               div_start;
    logic               div_done;
    logic [DIV_N_W-1:0] div_q;

    twcm_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    twcm_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    twcm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({tex_h, 16'd0}),
        .divisor  (lh_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // clamp texture sizes to 1..MAX_TEX_SIZE
    always_comb
    begin
        if (cfg.texture_width == 9'd0)
            tex_w = 9'd1;
        else if (int'(cfg.texture_width) > MAX_TEX_SIZE)
            tex_w = 9'(MAX_TEX_SIZE);
        else
            tex_w = cfg.texture_width;

        if (cfg.texture_height == 9'd0)
            tex_h = 9'd1;
        else if (int'(cfg.texture_height) > MAX_TEX_SIZE)
            tex_h = 9'(MAX_TEX_SIZE);
        else
            tex_h = cfg.texture_height;
    end

    assign hit.ready = (state_reg == ST_IDLE);
    assign accept    = hit.valid & hit.ready;
    assign out_free  = !out_valid_reg || pixel.ready;
    assign emit      = (state_reg == ST_EMIT) && out_free;
    assign div_start = (state_reg == ST_HIT);

    assign ds_masked = hit.draw_start & 11'(MAX_SCREEN - 1);
    assign de_masked = hit.draw_end & 11'(MAX_SCREEN - 1);

    assign dx_pos = !hit.ray_dir_x[20] && (hit.ray_dir_x != '0);
    assign dy_pos = !hit.ray_dir_y[20] && (hit.ray_dir_y != '0);

    always_comb
    begin
        if (!hit.hit_side)
            face_new = dx_pos ? FACE_NORTH : FACE_SOUTH;
        else
            face_new = dy_pos ? FACE_WEST : FACE_EAST;
    end

    assign frac      = base_reg + mul_p[31:16];
    assign col       = mul_p[24:16];
    assign tcol_full = tex_w - 9'd1 - col;
    assign start_row = $signed({6'd0, row_reg})
                     - $signed({6'd0, cfg.screen_height[11:1]})
                     + $signed({2'd0, lh_reg[15:1]});
    assign ty        = tex_position_reg[24:16] & (tex_h - 9'd1);

    // operand select for the shared multiplier
    always_comb
    begin
        case (state_reg)
            ST_HIT:
            begin
                mul_a = $signed(MUL_W'(dist_reg));
                mul_b = MUL_W'(dir_reg);
            end
            ST_FRAC:
            begin
                mul_a = $signed(MUL_W'(frac));
                mul_b = $signed(MUL_W'(tex_w));
            end
            ST_POS:
            begin
                mul_a = MUL_W'(start_row);
                mul_b = $signed(MUL_W'(tex_step_reg));
            end
            ST_TEX:
            begin
                mul_a = $signed(MUL_W'(ty));
                mul_b = $signed(MUL_W'(tex_w));
            end
            ST_FRM, ST_EMIT:
            begin
                mul_a = $signed(MUL_W'(row_reg));
                mul_b = $signed(MUL_W'(cfg.screen_width));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (!hit.op)
                        state_next = ST_HIT;
                    else if (row_reg < row_limit_reg)
                        state_next = ST_TEX;
                end
            end
            ST_HIT:  state_next = ST_FRAC;
            ST_FRAC: state_next = ST_COL;
            ST_COL:  state_next = ST_DIV;
            ST_DIV:  state_next = div_done ? ST_POS : ST_DIV;
            ST_POS:  state_next = ST_POSW;
            ST_POSW: state_next = ST_IDLE;
            ST_TEX:  state_next = ST_FRM;
            ST_FRM:  state_next = ST_EMIT;
            ST_EMIT: state_next = out_free ? ST_IDLE : ST_EMIT;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            row_reg           <= '0;
            row_limit_reg     <= '0;
            tex_position_reg  <= '0;
            tex_step_reg      <= '0;
            tex_column_reg    <= '0;
            face_sel_reg      <= FACE_NORTH;
            screen_column_reg <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (accept && !hit.op)
            begin
                row_reg           <= ds_masked;
                row_limit_reg     <= de_masked;
                screen_column_reg <= hit.column;
                face_sel_reg      <= face_new;
            end

            if (state_reg == ST_COL)
                tex_column_reg <= TCOL_W'(tcol_full);
            if ((state_reg == ST_DIV) && div_done)
                tex_step_reg <= div_q;
            if (state_reg == ST_POSW)
                tex_position_reg <= mul_p[31:0];

            // advance the column once the pixel item is handed over
            if (emit)
            begin
                tex_position_reg <= tex_position_reg + 32'(tex_step_reg);
                row_reg          <= row_reg + 11'd1;
            end

            if (emit)
                out_valid_reg <= 1'b1;
            else if (pixel.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && !hit.op)
        begin
            base_reg <= hit.hit_side ? hit.player_x[15:0] : hit.player_y[15:0];
            dist_reg <= hit.wall_distance;
            dir_reg  <= hit.hit_side ? hit.ray_dir_x : hit.ray_dir_y;
            lh_reg   <= (hit.line_height == 16'd0) ? 16'd1 : hit.line_height;
        end

        if (state_reg == ST_FRM)
            texel_reg <= mul_p[15:0] + 16'(tex_column_reg);

        if (emit)
        begin
            out_face_reg  <= face_sel_reg;
            out_texel_reg <= texel_reg;
            out_frame_reg <= mul_p[21:0] + 22'(screen_column_reg);
            out_last_reg  <= ({1'b0, row_reg} + 12'd1) == {1'b0, row_limit_reg};
        end
    end

    assign pixel.valid         = out_valid_reg;
    assign pixel.face          = out_face_reg;
    assign pixel.texel_address = out_texel_reg;
    assign pixel.frame_address = out_frame_reg;
    assign pixel.last_row      = out_last_reg;

endmodule

>>> dv/textured_wall_column_mapper_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// textured_wall_column_mapper_tb
// Self-checking bench: wall hits and pixel ticks in, texel/frame addresses out.
// Every accepted item is run through a local mapping of column state and
// registers. The expected pixel items are queued and compared field by field
// with what the block returns. Phases cover directed corners, register
// extremes, output back-pressure and long random runs of columns.
// ----------------------------------------------------------------------------
module textured_wall_column_mapper_tb;
    import twcm_pkg::*;

    localparam logic OP_SETUP = 1'b0;
    localparam logic OP_PIXEL = 1'b1;
    localparam int   SETTLE_CYCLES = 64;
    localparam int   CYCLE_LIMIT   = 600000;

    typedef struct {
        logic               op;
        logic               hit_side;
        logic [23:0]        player_x;
        logic [23:0]        player_y;
        logic signed [20:0] ray_dir_x;
        logic signed [20:0] ray_dir_y;
        logic [23:0]        wall_distance;
        logic [15:0]        line_height;
        logic [10:0]        draw_start;
        logic [10:0]        draw_end;
        logic [10:0]        column;
    } wall_hit_t;

    typedef struct {
        logic [1:0]  face;
        logic [15:0] texel_address;
        logic [21:0] frame_address;
        logic        last_row;
    } pixel_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    twcm_hit_if hit_ch();
    twcm_pix_if pixel_ch();

    textured_wall_column_mapper u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .hit     (hit_ch),
        .pixel   (pixel_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #10 clk = ~clk;

    // register copies
    logic [8:0]  tex_w_reg;
    logic [8:0]  tex_h_reg;
    logic [11:0] scr_w_reg;
    logic [11:0] scr_h_reg;

    // column state
    logic [10:0] col_row;
    logic [10:0] col_row_limit;
    logic [31:0] col_tex_pos;
    logic [31:0] col_tex_step;
    logic [7:0]  col_tex_column;
    logic [1:0]  col_face;
    logic [10:0] col_screen_column;

    pixel_t pending_pixels[$];
    pixel_t pixel_due;
    int     mismatch_count = 0;
    int     items_sent     = 0;
    int     burst_left     = 0;
    bit     sender_steady  = 1'b0;
    int     holdoff_cycles = 0;
    int     cycle_count    = 0;

    function automatic logic [8:0] clamp_tex_size(input logic [8:0] v);
        if (v == 9'd0)
            return 9'd1;
        if (v > 9'd256)
            return 9'd256;
        return v;
    endfunction

    // Column setup or next pixel; queue the pixel item it yields, if any.
    task automatic map_wall_pixel(input wall_hit_t item);
        logic [8:0]         tw;
        logic [8:0]         th;
        logic signed [20:0] dir;
        logic signed [47:0] offset;
        logic [15:0]        frac;
        logic [24:0]        scaled;
        logic [15:0]        lh;
        logic [31:0]        start;
        logic [31:0]        tex_row;
        logic [31:0]        texel;
        logic [31:0]        frame;
        pixel_t             px;
        tw = clamp_tex_size(tex_w_reg);
        th = clamp_tex_size(tex_h_reg);
        if (item.op == OP_SETUP)
        begin
            dir    = item.hit_side ? item.ray_dir_x : item.ray_dir_y;
            offset = $signed({1'b0, item.wall_distance}) * dir;
            frac   = (item.hit_side ? item.player_x[15:0] : item.player_y[15:0]) + offset[31:16];
            scaled = frac * tw;
            col_tex_column = 8'(tw - 9'd1 - scaled[24:16]);
            if (item.hit_side == 1'b0)
                col_face = (item.ray_dir_x > 0) ? FACE_NORTH : FACE_SOUTH;
            else
                col_face = (item.ray_dir_y > 0) ? FACE_WEST : FACE_EAST;
            lh = (item.line_height == 16'd0) ? 16'd1 : item.line_height;
            col_tex_step = ({23'd0, th} << 16) / {16'd0, lh};
            // negative start wraps in 32 bits, so the row is taken by floor
            start = {21'd0, item.draw_start} - {21'd0, scr_h_reg[11:1]} + {17'd0, lh[15:1]};
            col_tex_pos       = start * col_tex_step;
            col_row           = item.draw_start;
            col_row_limit     = item.draw_end;
            col_screen_column = item.column;
        end
        else if (col_row < col_row_limit)
        begin
            tex_row     = {16'd0, col_tex_pos[31:16]} & {23'd0, th - 9'd1};
            col_tex_pos = col_tex_pos + col_tex_step;
            texel       = tex_row * tw + col_tex_column;
            frame       = col_row * scr_w_reg + col_screen_column;
            px.face          = col_face;
            px.texel_address = texel[15:0];
            px.frame_address = frame[21:0];
            px.last_row      = (col_row + 11'd1 == col_row_limit);
            col_row = col_row + 11'd1;
            pending_pixels.push_back(px);
        end
    endtask

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && pixel_ch.valid === 1'b1 && pixel_ch.ready)
        begin
            if (pending_pixels.size() == 0)
            begin
                $error("pixel item with none expected: frame_address 0x%0h",
                       pixel_ch.frame_address);
                mismatch_count++;
            end
            else
            begin
                pixel_due = pending_pixels.pop_front();
                check_field("face", 32'(pixel_due.face), 32'(pixel_ch.face));
                check_field("texel_address", 32'(pixel_due.texel_address),
                            32'(pixel_ch.texel_address));
                check_field("frame_address", 32'(pixel_due.frame_address),
                            32'(pixel_ch.frame_address));
                check_field("last_row", 32'(pixel_due.last_row), 32'(pixel_ch.last_row));
            end
        end
    end

    // Receiver: changing stall patterns, or a long hold-off on request.
    initial
    begin : pixel_sink
        int mode_left;
        int stall_mode;
        int pattern_step;
        int hold_count;
        pixel_ch.ready = 1'b0;
        mode_left    = 0;
        stall_mode   = 0;
        pattern_step = 0;
        forever
        begin
            @(negedge clk);
            if (holdoff_cycles > 0)
            begin
                pixel_ch.ready <= 1'b0;
                hold_count = 0;
                while (hold_count < holdoff_cycles)
                begin
                    @(negedge clk);
                    hold_count++;
                end
                holdoff_cycles = 0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    stall_mode = $urandom_range(0, 3);
                    mode_left  = $urandom_range(40, 300);
                end
                mode_left--;
                pattern_step = (pattern_step + 1) % 5;
                case (stall_mode)
                    0: pixel_ch.ready <= 1'b1;
                    1: pixel_ch.ready <= ($urandom_range(0, 3) != 0);
                    2: pixel_ch.ready <= (pattern_step < 3);
                    default: pixel_ch.ready <= ($urandom_range(0, 9) < 3);
                endcase
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    task automatic idle_sender(input int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            hit_ch.valid <= 1'b0;
        end
    endtask

    task automatic send_hit(input wall_hit_t item);
        if (!sender_steady)
        begin
            if (burst_left == 0)
            begin
                idle_sender($urandom_range(1, 6));
                burst_left = $urandom_range(1, 20);
            end
            burst_left--;
        end
        @(negedge clk);
        hit_ch.valid         <= 1'b1;
        hit_ch.op            <= item.op;
        hit_ch.hit_side      <= item.hit_side;
        hit_ch.player_x      <= item.player_x;
        hit_ch.player_y      <= item.player_y;
        hit_ch.ray_dir_x     <= item.ray_dir_x;
        hit_ch.ray_dir_y     <= item.ray_dir_y;
        hit_ch.wall_distance <= item.wall_distance;
        hit_ch.line_height   <= item.line_height;
        hit_ch.draw_start    <= item.draw_start;
        hit_ch.draw_end      <= item.draw_end;
        hit_ch.column        <= item.column;
        @(posedge clk);
        while (!hit_ch.ready)
            @(posedge clk);
        map_wall_pixel(item);
        items_sent++;
    endtask

    // Drop valid, wait for every pixel item, then let any setup finish.
    task automatic wait_all_pixels();
        @(negedge clk);
        hit_ch.valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic apb_transfer(input logic is_write, input logic [1:0] idx,
                                input logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (is_write)
        begin
            case (idx)
                REG_TEX_W: tex_w_reg = value[8:0];
                REG_TEX_H: tex_h_reg = value[8:0];
                REG_SCR_W: scr_w_reg = value[11:0];
                default:   scr_h_reg = value[11:0];
            endcase
        end
        else
        begin
            case (idx)
                REG_TEX_W: check_field("prdata texture_width", {23'd0, tex_w_reg}, prdata);
                REG_TEX_H: check_field("prdata texture_height", {23'd0, tex_h_reg}, prdata);
                REG_SCR_W: check_field("prdata screen_width", {20'd0, scr_w_reg}, prdata);
                default:   check_field("prdata screen_height", {20'd0, scr_h_reg}, prdata);
            endcase
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic write_config(input int tw, input int th, input int sw, input int sh);
        wait_all_pixels();
        apb_transfer(1'b1, REG_TEX_W, tw);
        apb_transfer(1'b1, REG_TEX_H, th);
        apb_transfer(1'b1, REG_SCR_W, sw);
        apb_transfer(1'b1, REG_SCR_H, sh);
    endtask

    function automatic wall_hit_t random_hit(input logic op);
        wall_hit_t h;
        h.op            = op;
        h.hit_side      = 1'($urandom_range(0, 1));
        h.player_x      = 24'($urandom);
        h.player_y      = 24'($urandom);
        h.ray_dir_x     = 21'($urandom);
        h.ray_dir_y     = 21'($urandom);
        h.wall_distance = 24'($urandom);
        h.draw_start    = 11'($urandom);
        h.draw_end      = 11'($urandom);
        h.column        = 11'($urandom);
        if ($urandom_range(0, 15) == 0)
            h.ray_dir_x = '0;
        if ($urandom_range(0, 15) == 0)
            h.ray_dir_y = '0;
        if ($urandom_range(0, 3) == 0)
            h.wall_distance = 24'($urandom_range(0, 24'h03FFFF));
        case ($urandom_range(0, 9))
            0:       h.line_height = 16'($urandom);
            1:       h.line_height = 16'd0;
            default: h.line_height = 16'($urandom_range(1, 600));
        endcase
        return h;
    endfunction

    task automatic run_column(input wall_hit_t geom, input int ticks);
        send_hit(geom);
        repeat (ticks)
            send_hit(random_hit(OP_PIXEL));
    endtask

    function automatic int pick_tex_size();
        case ($urandom_range(0, 7))
            0:       return $urandom_range(0, 511);
            1:       return 1;
            2:       return 256;
            3:       return $urandom_range(1, 256);
            default: return 1 << $urandom_range(1, 8);
        endcase
    endfunction

    function automatic int pick_screen_size();
        case ($urandom_range(0, 5))
            0:       return $urandom_range(0, 4095);
            1:       return 4095;
            default: return $urandom_range(320, 2048);
        endcase
    endfunction

    task automatic test_directed_columns();
        wall_hit_t g;
        // north face; one tick past the end gives nothing
        g = random_hit(OP_SETUP);
        g.hit_side    = 1'b0;
        g.ray_dir_x   = 21'sd65536;
        g.line_height = 16'd200;
        g.draw_start  = 11'd100;
        g.draw_end    = 11'd103;
        run_column(g, 4);
        // south face on zero x direction, field extremes, negative texture position
        g.ray_dir_x     = '0;
        g.ray_dir_y     = 21'h100000;
        g.wall_distance = 24'hFFFFFF;
        g.player_x      = 24'hFFFFFF;
        g.player_y      = 24'hFFFFFF;
        g.line_height   = 16'd1;
        g.draw_start    = 11'd0;
        g.draw_end      = 11'd2;
        g.column        = 11'd0;
        run_column(g, 2);
        // west face, zero line height, then a restart mid-column
        g.hit_side      = 1'b1;
        g.ray_dir_y     = 21'sd1;
        g.ray_dir_x     = 21'h0FFFFF;
        g.player_x      = '0;
        g.player_y      = '0;
        g.wall_distance = '0;
        g.line_height   = 16'd0;
        g.draw_start    = 11'd2045;
        g.draw_end      = 11'd2047;
        g.column        = 11'h7FF;
        run_column(g, 1);
        // east face, tallest line
        g.ray_dir_y   = 21'h100000;
        g.ray_dir_x   = 21'h100000;
        g.line_height = 16'hFFFF;
        g.draw_start  = 11'd2046;
        g.draw_end    = 11'd2047;
        g.column      = 11'd1234;
        run_column(g, 2);
        // empty columns: equal bounds, then end below start
        g.ray_dir_y  = '0;
        g.draw_start = 11'd500;
        g.draw_end   = 11'd500;
        run_column(g, 1);
        g.draw_start = 11'd1000;
        g.draw_end   = 11'd10;
        run_column(g, 1);
    endtask

    task automatic test_register_access();
        wait_all_pixels();
        apb_transfer(1'b0, REG_TEX_W, '0);
        apb_transfer(1'b0, REG_TEX_H, '0);
        apb_transfer(1'b0, REG_SCR_W, '0);
        apb_transfer(1'b0, REG_SCR_H, '0);
        write_config($urandom, $urandom, $urandom, $urandom);
        apb_transfer(1'b0, REG_TEX_W, '0);
        apb_transfer(1'b0, REG_TEX_H, '0);
        apb_transfer(1'b0, REG_SCR_W, '0);
        apb_transfer(1'b0, REG_SCR_H, '0);
    endtask

    task automatic test_config_extremes();
        int        tex_w_set[5] = '{0, 1, 256, 511, 100};
        int        tex_h_set[5] = '{0, 1, 256, 511, 48};
        int        scr_w_set[5] = '{0, 1, 2048, 4095, 1000};
        int        scr_h_set[5] = '{0, 1, 2048, 4095, 3000};
        wall_hit_t g;
        for (int i = 0; i < 5; i++)
        begin
            write_config(tex_w_set[i], tex_h_set[i], scr_w_set[i], scr_h_set[i]);
            // bottom rows push the frame address past its width
            g = random_hit(OP_SETUP);
            g.draw_start = 11'd2040;
            g.draw_end   = 11'd2047;
            run_column(g, 7);
            g = random_hit(OP_SETUP);
            g.draw_start = 11'($urandom_range(0, 20));
            g.draw_end   = g.draw_start + 11'd6;
            run_column(g, 6);
        end
    endtask

    task automatic test_output_backpressure();
        wall_hit_t g;
        write_config(64, 64, 640, 480);
        sender_steady  = 1'b1;
        holdoff_cycles = 400;
        g = random_hit(OP_SETUP);
        g.line_height = 16'd300;
        g.draw_start  = 11'd200;
        g.draw_end    = 11'd240;
        run_column(g, 40);
        wait_all_pixels();
        sender_steady = 1'b0;
        g = random_hit(OP_SETUP);
        g.draw_start = 11'd10;
        g.draw_end   = 11'd30;
        run_column(g, 20);
    endtask

    task automatic test_random_columns();
        wall_hit_t g;
        int        len;
        int        ticks;
        int        sel;
        int        phase_end;
        for (int phase = 0; phase < 6; phase++)
        begin
            write_config(pick_tex_size(), pick_tex_size(), pick_screen_size(),
                         pick_screen_size());
            sender_steady = ($urandom_range(0, 3) == 0);
            phase_end     = items_sent + 190;
            while (items_sent < phase_end)
            begin
                sel = $urandom_range(0, 99);
                g   = random_hit(OP_SETUP);
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
                if (sel < 90)
                begin
                    g.draw_start = 11'($urandom_range(0, 2047 - len));
                    g.draw_end   = 11'(int'(g.draw_start) + len);
                end
                if (sel < 75)
                    ticks = len + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0);
                else if (sel < 90)
                    ticks = $urandom_range(0, len - 1);   // restart mid-column
                else
                    ticks = $urandom_range(0, 4);         // arbitrary bounds
                run_column(g, ticks);
            end
        end
    endtask

    initial
    begin
        rst_n   = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        hit_ch.valid         = 1'b0;
        hit_ch.op            = OP_SETUP;
        hit_ch.hit_side      = 1'b0;
        hit_ch.player_x      = '0;
        hit_ch.player_y      = '0;
        hit_ch.ray_dir_x     = '0;
        hit_ch.ray_dir_y     = '0;
        hit_ch.wall_distance = '0;
        hit_ch.line_height   = '0;
        hit_ch.draw_start    = '0;
        hit_ch.draw_end      = '0;
        hit_ch.column        = '0;
        tex_w_reg = TEX_W_RST;
        tex_h_reg = TEX_H_RST;
        scr_w_reg = SCR_W_RST;
        scr_h_reg = SCR_H_RST;
        col_row           = '0;
        col_row_limit     = '0;
        col_tex_pos       = '0;
        col_tex_step      = '0;
        col_tex_column    = '0;
        col_face          = FACE_NORTH;
        col_screen_column = '0;
        repeat (2)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_columns();
        test_register_access();
        test_config_extremes();
        test_output_backpressure();
        test_random_columns();
        wait_all_pixels();

        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> files.f
rtl/twcm_pkg.sv
rtl/twcm_if.sv
rtl/twcm_cfg.sv
rtl/twcm_mul.sv
rtl/twcm_div.sv
rtl/textured_wall_column_mapper.sv
dv/textured_wall_column_mapper_tb.sv
